### rtl/rbmc_pkg.sv
// Shared types and constants for the balance robot motor controller.
package rbmc_pkg;

	// multiplier operand of the serial MAC: one gain, taken two bits per cycle
	localparam int GAIN_W   = 16;
	localparam int DIGIT_W  = 2;
	localparam int N_DIGITS = GAIN_W / DIGIT_W;
	localparam int CNT_W    = $clog2(N_DIGITS);

	// speed state formats
	localparam int SPEED_W    = 26;
	localparam int INT_W      = 24;
	localparam int SPEED_FRAC = 8;

	// 0.86 / 0.14 low-pass weights in Q16
	localparam logic [GAIN_W-1:0] LPF_KEEP = 16'd56361;
	localparam logic [GAIN_W-1:0] LPF_TAKE = 16'd9175;
	localparam int LPF_SHIFT = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_ANGLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_DAMPING        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_INTEGRAL_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_DAMPING         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT         = 3'd6;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

### rtl/rbmc_mac.sv
// Digit-serial multiply-accumulate: signed multiplicand times 16-bit unsigned gain.
module rbmc_mac #(
	parameter int ACC_W = 44
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rbmc_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [ACC_W-1:0]             mcand,
	input  logic [rbmc_pkg::GAIN_W-1:0]         mplier,
	output rbmc_pkg::mac_stat_t                 stat,
	output logic signed [ACC_W-1:0]             acc
);

	localparam logic [rbmc_pkg::CNT_W-1:0] LAST_DIGIT =
		rbmc_pkg::CNT_W'(rbmc_pkg::N_DIGITS - 1);

	logic signed [ACC_W-1:0]            m1_q;
	logic signed [ACC_W-1:0]            m3_q;
	logic signed [ACC_W-1:0]            acc_q;
	logic signed [ACC_W-1:0]            addend;
	logic [rbmc_pkg::GAIN_W-1:0]        mpl_q;
	logic [rbmc_pkg::CNT_W-1:0]         cnt_q;
	logic                               busy_q;
	logic                               done_q;

	// one two-bit digit of the gain per cycle, low digit first
	always_comb begin
		unique case (mpl_q[rbmc_pkg::DIGIT_W-1:0])
			2'd0: addend = '0;
			2'd1: addend = m1_q;
			2'd2: addend = m1_q <<< 1;
			2'd3: addend = m3_q;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + rbmc_pkg::CNT_W'(1);
				if (cnt_q == LAST_DIGIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			m1_q  <= mcand;
			m3_q  <= mcand + (mcand <<< 1);
			mpl_q <= mplier;
			if (ctrl.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			m1_q  <= m1_q <<< rbmc_pkg::DIGIT_W;
			m3_q  <= m3_q <<< rbmc_pkg::DIGIT_W;
			mpl_q <= mpl_q >> rbmc_pkg::DIGIT_W;
		end
	end

	// {busy, done}
	assign stat = {busy_q, done_q};
	assign acc  = acc_q;

endmodule

### rtl/balance_robot_motor_controller.sv
// Balance robot motor controller top: PD balance, PI speed, yaw damping, drive clamp.
// One item at a time: a new input is taken only once the last result has entered the
// output register, which waits while the output is not taken; seven serial products
// on one MAC at two gain bits per cycle set the pace.
// Reset: registers load their defaults, filter and integral clear, output empties;
// the block is ready right after reset.
module balance_robot_motor_controller #(
	parameter int INTEGRAL_BOUND = 10000,
	parameter int FRACTION_BITS  = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// pitch_angle[16:0], raw_gyro_x[32:17], raw_gyro_z[48:33],
	// left_count[64:49], right_count[80:65], zero pad [87:81]
	input  logic [87:0]                           s_axis_tdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// left_magnitude[14:0], left_forward[15], right_magnitude[30:16], right_forward[31]
	output logic [31:0]                           m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rbmc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rbmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int ACC_W = (FRACTION_BITS + 34 > 44) ? FRACTION_BITS + 34 : 44;
	localparam int RES_W = 34;
	localparam int ISUM_W = rbmc_pkg::SPEED_W + 1;

	localparam logic signed [ACC_W-1:0] BIAS_BAL =
		ACC_W'((64'd1 << (2 * FRACTION_BITS)) - 64'd1);
	localparam logic signed [ACC_W-1:0] BIAS_SPD =
		ACC_W'((64'd1 << (FRACTION_BITS + rbmc_pkg::SPEED_FRAC)) - 64'd1);
	localparam logic signed [ACC_W-1:0] BIAS_TRN =
		ACC_W'((64'd1 << FRACTION_BITS) - 64'd1);
	localparam logic signed [ACC_W-1:0] LPF_HALF =
		ACC_W'(64'd1 << (rbmc_pkg::LPF_SHIFT - 1));

	localparam logic signed [ISUM_W-1:0] BOUND_W =
		ISUM_W'(INTEGRAL_BOUND * 256);
	localparam logic signed [rbmc_pkg::INT_W-1:0] BOUND_POS =
		rbmc_pkg::INT_W'(INTEGRAL_BOUND * 256);
	localparam logic signed [rbmc_pkg::INT_W-1:0] BOUND_NEG =
		rbmc_pkg::INT_W'(-(INTEGRAL_BOUND * 256));

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BAL_P = 4'd1;
	localparam logic [3:0] S_BAL_D = 4'd2;
	localparam logic [3:0] S_BAL_Q = 4'd3;
	localparam logic [3:0] S_LPF_A = 4'd4;
	localparam logic [3:0] S_LPF_B = 4'd5;
	localparam logic [3:0] S_LPF_Q = 4'd6;
	localparam logic [3:0] S_INT   = 4'd7;
	localparam logic [3:0] S_SPD_P = 4'd8;
	localparam logic [3:0] S_SPD_I = 4'd9;
	localparam logic [3:0] S_SPD_Q = 4'd10;
	localparam logic [3:0] S_TRN   = 4'd11;
	localparam logic [3:0] S_TRN_Q = 4'd12;
	localparam logic [3:0] S_SUM   = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	// configuration registers
	logic signed [16:0]                 upright_angle_q;
	logic [rbmc_pkg::GAIN_W-1:0]        tilt_gain_q;
	logic [rbmc_pkg::GAIN_W-1:0]        tilt_damping_q;
	logic [rbmc_pkg::GAIN_W-1:0]        speed_gain_q;
	logic [rbmc_pkg::GAIN_W-1:0]        speed_integral_gain_q;
	logic [rbmc_pkg::GAIN_W-1:0]        yaw_damping_q;
	logic [14:0]                        drive_limit_q;

	// control and state
	logic [3:0]                         state_q;
	logic                               issued_q;
	logic                               out_valid_q;
	logic signed [rbmc_pkg::SPEED_W-1:0] smoothed_q;
	logic signed [rbmc_pkg::INT_W-1:0]  integral_q;

	// per-item payload
	logic signed [17:0]                 diff_q;
	logic signed [16:0]                 ngx_q;
	logic signed [15:0]                 gz_q;
	logic signed [16:0]                 sum_q;
	logic signed [RES_W-1:0]            bal_q;
	logic signed [RES_W-1:0]            spd_q;
	logic signed [RES_W-1:0]            trn_q;
	logic signed [RES_W-1:0]            left_q;
	logic signed [RES_W-1:0]            right_q;
	logic [31:0]                        out_data_q;

	// input unpack
	logic signed [16:0]                 in_pitch;
	logic signed [15:0]                 in_gx;
	logic signed [15:0]                 in_gz;
	logic signed [15:0]                 in_lc;
	logic signed [15:0]                 in_rc;

	// MAC hookup
	rbmc_pkg::mac_ctrl_t                mac_ctrl;
	rbmc_pkg::mac_stat_t                mac_stat;
	logic signed [ACC_W-1:0]            mcand;
	logic [rbmc_pkg::GAIN_W-1:0]        mplier;
	logic signed [ACC_W-1:0]            mac_acc;
	logic                               mac_step;
	logic [3:0]                         step_next;

	// rescaling of the accumulator
	logic signed [ACC_W-1:0]            bal_sum;
	logic signed [ACC_W-1:0]            bal_sh;
	logic signed [ACC_W-1:0]            spd_sum;
	logic signed [ACC_W-1:0]            spd_sh;
	logic signed [ACC_W-1:0]            trn_sum;
	logic signed [ACC_W-1:0]            trn_sh;
	logic signed [ACC_W-1:0]            lpf_sum;
	logic signed [ACC_W-1:0]            lpf_sh;
	logic signed [ISUM_W-1:0]           int_sum;
	logic signed [rbmc_pkg::INT_W-1:0]  int_next;

	logic                               accept;
	logic                               out_free;
	logic [15:0]                        left_code;
	logic [15:0]                        right_code;

	// {forward, magnitude} of a drive after clamping to +/-lim
	function automatic logic [15:0] drive_code(input logic signed [RES_W-1:0] v,
			input logic [14:0] lim);
		logic signed [RES_W-1:0] lim_s;
		logic signed [RES_W-1:0] neg_lim;
		logic [RES_W-1:0]        absv;
		logic [14:0]             mag;
		logic                    fwd;
		lim_s   = RES_W'(lim);
		neg_lim = -lim_s;
		absv    = v[RES_W-1] ? -v : v;
		if (v > lim_s || v < neg_lim) begin
			mag = lim;
		end else begin
			mag = absv[14:0];
		end
		// a zero limit clamps everything to zero, which is not forward
		fwd = (v > 0) && (lim != 15'd0);
		return {fwd, mag};
	endfunction

	assign in_pitch = $signed(s_axis_tdata[16:0]);
	assign in_gx    = $signed(s_axis_tdata[32:17]);
	assign in_gz    = $signed(s_axis_tdata[48:33]);
	assign in_lc    = $signed(s_axis_tdata[64:49]);
	assign in_rc    = $signed(s_axis_tdata[80:65]);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upright_angle_q       <= '0;
			tilt_gain_q           <= 16'd5120;
			tilt_damping_q        <= 16'd346;
			speed_gain_q          <= 16'd2560;
			speed_integral_gain_q <= 16'd205;
			yaw_damping_q         <= 16'd154;
			drive_limit_q         <= 15'd6900;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbmc_pkg::REG_UPRIGHT_ANGLE:       upright_angle_q <= $signed(cfg_data[16:0]);
				rbmc_pkg::REG_TILT_GAIN:           tilt_gain_q <= cfg_data[15:0];
				rbmc_pkg::REG_TILT_DAMPING:        tilt_damping_q <= cfg_data[15:0];
				rbmc_pkg::REG_SPEED_GAIN:          speed_gain_q <= cfg_data[15:0];
				rbmc_pkg::REG_SPEED_INTEGRAL_GAIN: speed_integral_gain_q <= cfg_data[15:0];
				rbmc_pkg::REG_YAW_DAMPING:         yaw_damping_q <= cfg_data[15:0];
				rbmc_pkg::REG_DRIVE_LIMIT:         drive_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign mac_step = (state_q == S_BAL_P) || (state_q == S_BAL_D) ||
		(state_q == S_LPF_A) || (state_q == S_LPF_B) || (state_q == S_SPD_P) ||
		(state_q == S_SPD_I) || (state_q == S_TRN);

	// operand selection for each product step
	always_comb begin
		mac_ctrl.start = mac_step && !issued_q;
		mac_ctrl.clear = 1'b0;
		mcand          = '0;
		mplier         = '0;
		step_next      = S_IDLE;
		unique case (state_q)
			S_BAL_P: begin
				mac_ctrl.clear = 1'b1;
				mcand          = ACC_W'(diff_q);
				mplier         = tilt_gain_q;
				step_next      = S_BAL_D;
			end
			S_BAL_D: begin
				// gyro term carries F extra fraction bits
				mcand     = ACC_W'(ngx_q) <<< FRACTION_BITS;
				mplier    = tilt_damping_q;
				step_next = S_BAL_Q;
			end
			S_LPF_A: begin
				mac_ctrl.clear = 1'b1;
				mcand          = ACC_W'(smoothed_q);
				mplier         = rbmc_pkg::LPF_KEEP;
				step_next      = S_LPF_B;
			end
			S_LPF_B: begin
				mcand     = ACC_W'(sum_q) <<< rbmc_pkg::SPEED_FRAC;
				mplier    = rbmc_pkg::LPF_TAKE;
				step_next = S_LPF_Q;
			end
			S_SPD_P: begin
				mac_ctrl.clear = 1'b1;
				mcand          = ACC_W'(smoothed_q);
				mplier         = speed_gain_q;
				step_next      = S_SPD_I;
			end
			S_SPD_I: begin
				mcand     = ACC_W'(integral_q);
				mplier    = speed_integral_gain_q;
				step_next = S_SPD_Q;
			end
			S_TRN: begin
				mac_ctrl.clear = 1'b1;
				mcand          = ACC_W'(gz_q);
				mplier         = yaw_damping_q;
				step_next      = S_TRN_Q;
			end
			default: ;
		endcase
	end

	rbmc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.mcand  (mcand),
		.mplier (mplier),
		.stat   (mac_stat),
		.acc    (mac_acc)
	);

	// truncation toward zero: bias negative values before the arithmetic shift
	assign bal_sum = mac_acc + (mac_acc[ACC_W-1] ? BIAS_BAL : ACC_W'(0));
	assign bal_sh  = bal_sum >>> (2 * FRACTION_BITS);
	assign spd_sum = mac_acc + (mac_acc[ACC_W-1] ? BIAS_SPD : ACC_W'(0));
	assign spd_sh  = spd_sum >>> (FRACTION_BITS + rbmc_pkg::SPEED_FRAC);
	assign trn_sum = mac_acc + (mac_acc[ACC_W-1] ? BIAS_TRN : ACC_W'(0));
	assign trn_sh  = trn_sum >>> FRACTION_BITS;
	// round half away from zero
	assign lpf_sum = mac_acc + LPF_HALF - ACC_W'(mac_acc[ACC_W-1]);
	assign lpf_sh  = lpf_sum >>> rbmc_pkg::LPF_SHIFT;

	assign int_sum = ISUM_W'(integral_q) + ISUM_W'(smoothed_q);
	always_comb begin
		priority if (int_sum > BOUND_W) begin
			int_next = BOUND_POS;
		end else if (int_sum < -BOUND_W) begin
			int_next = BOUND_NEG;
		end else begin
			int_next = int_sum[rbmc_pkg::INT_W-1:0];
		end
	end

	assign left_code  = drive_code(left_q, drive_limit_q);
	assign right_code = drive_code(right_q, drive_limit_q);

	// sequencer, speed state and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			smoothed_q  <= '0;
			integral_q  <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (mac_step) begin
				if (!issued_q) begin
					issued_q <= 1'b1;
				end else if (mac_stat.done) begin
					issued_q <= 1'b0;
					state_q  <= step_next;
				end
			end else begin
				unique case (state_q)
					S_IDLE:  if (accept) state_q <= S_BAL_P;
					S_BAL_Q: state_q <= S_LPF_A;
					S_LPF_Q: begin
						smoothed_q <= lpf_sh[rbmc_pkg::SPEED_W-1:0];
						state_q    <= S_INT;
					end
					S_INT: begin
						integral_q <= int_next;
						state_q    <= S_SPD_P;
					end
					S_SPD_Q: state_q <= S_TRN;
					S_TRN_Q: state_q <= S_SUM;
					S_SUM:   state_q <= S_OUT;
					S_OUT:   if (out_free) state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= 18'(in_pitch) - 18'(upright_angle_q);
			ngx_q  <= -17'(in_gx);
			gz_q   <= in_gz;
			sum_q  <= 17'(in_lc) + 17'(in_rc);
		end
		if (state_q == S_BAL_Q) begin
			bal_q <= bal_sh[RES_W-1:0];
		end
		if (state_q == S_SPD_Q) begin
			spd_q <= spd_sh[RES_W-1:0];
		end
		if (state_q == S_TRN_Q) begin
			trn_q <= trn_sh[RES_W-1:0];
		end
		if (state_q == S_SUM) begin
			// speed term enters negated
			left_q  <= bal_q - spd_q + trn_q;
			right_q <= bal_q - spd_q - trn_q;
		end
		if (state_q == S_OUT && out_free) begin
			out_data_q <= {right_code, left_code};
		end
	end

	a_integral_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(integral_q <= BOUND_POS) && (integral_q >= BOUND_NEG))
		else $error("speed integral outside its bound");

	a_done_only_when_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> (issued_q && mac_step))
		else $error("MAC finished with no product outstanding");

	a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!mac_stat.busy && !issued_q))
		else $error("MAC active while sequencer idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_BAL_P && !issued_q))
		else $error("accepted transaction did not start the balance product");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT && $stable(out_data_q)))
		else $error("result overwrote a pending output transaction");

endmodule
